### hw/rtl/slefp_pkg.sv
`timescale 1ns / 1ps

package slefp_pkg;

    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;
    localparam int POS_W     = 4;

    localparam logic [7:0] CH_START = 8'h21;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SP    = 8'h20;

    localparam logic [POS_W-1:0] FRAME_IDLE  = 4'd0;
    localparam logic [POS_W-1:0] FRAME_FIRST = 4'd1;
    localparam logic [POS_W-1:0] FRAME_LAST  = 4'd8;
    localparam logic [POS_W-1:0] FRAME_END   = 4'd9;

    typedef enum logic [1:0] {
        KIND_ECHO   = 2'd0,
        KIND_LINE   = 2'd1,
        KIND_STATUS = 2'd2
    } t_item_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BINARY_MODE   = 2'd0,
        CFG_ECHO_ENABLE   = 2'd1,
        CFG_ACCEPT_ENABLE = 2'd2,
        CFG_LINE_LIMIT    = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        SEL_CHAR,
        SEL_BS,
        SEL_SP,
        SEL_LINE,
        SEL_STATUS
    } t_out_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ECHO_CHAR,
        ST_ECHO_BS1,
        ST_ECHO_SP,
        ST_ECHO_BS2,
        ST_DUMP,
        ST_STATUS
    } t_state;

    typedef struct packed {
        logic     load_char;
        logic     frame_step;
        logic     line_end;
        logic     store_char;
        logic     fill_dec;
        logic     idx_inc;
        logic     status_load;
        logic     status_acc;
        logic     emit;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic binary_mode;
        logic echo_en;
        logic accept_en;
        logic is_eol;
        logic is_bs;
        logic fill_zero;
        logic full;
        logic dump_last;
        logic out_free;
    } t_stat;

endpackage

### hw/rtl/slefp_ram.sv
`timescale 1ns / 1ps

module slefp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/slefp_ctrl.sv
`timescale 1ns / 1ps

module slefp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  slefp_pkg::t_stat i_stat,
    output slefp_pkg::t_cmd  o_cmd
);

    import slefp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_stall    = 1'b1;
        o_cmd         = '0;
        o_cmd.out_sel = SEL_STATUS;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_char = 1'b1;
                    n_state         = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.status_load = 1'b1;
                priority if (i_stat.binary_mode) begin
                    o_cmd.frame_step = 1'b1;
                    o_cmd.status_acc = 1'b1;
                    n_state          = ST_STATUS;
                end else if (i_stat.is_eol) begin
                    o_cmd.line_end   = 1'b1;
                    o_cmd.status_acc = 1'b1;
                    n_state          = i_stat.fill_zero ? ST_STATUS : ST_DUMP;
                end else if (i_stat.is_bs) begin
                    o_cmd.status_acc = i_stat.accept_en;
                    n_state          = ST_STATUS;
                    if (i_stat.accept_en && !i_stat.fill_zero) begin
                        o_cmd.fill_dec = 1'b1;
                        if (i_stat.echo_en) begin
                            n_state = ST_ECHO_BS1;
                        end
                    end
                end else if (i_stat.full || !i_stat.accept_en) begin
                    o_cmd.status_acc = 1'b0;
                    n_state          = ST_STATUS;
                end else begin
                    o_cmd.store_char = 1'b1;
                    o_cmd.status_acc = 1'b1;
                    n_state          = i_stat.echo_en ? ST_ECHO_CHAR : ST_STATUS;
                end
            end
            ST_ECHO_CHAR: begin
                o_cmd.out_sel = SEL_CHAR;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_STATUS;
                end
            end
            ST_ECHO_BS1: begin
                o_cmd.out_sel = SEL_BS;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_ECHO_SP;
                end
            end
            ST_ECHO_SP: begin
                o_cmd.out_sel = SEL_SP;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_ECHO_BS2;
                end
            end
            ST_ECHO_BS2: begin
                o_cmd.out_sel = SEL_BS;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_STATUS;
                end
            end
            ST_DUMP: begin
                o_cmd.out_sel = SEL_LINE;
                if (i_stat.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                    if (i_stat.dump_last) begin
                        n_state = ST_STATUS;
                    end
                end
            end
            ST_STATUS: begin
                o_cmd.out_sel = SEL_STATUS;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/slefp_dp.sv
`timescale 1ns / 1ps

module slefp_dp #(
    parameter int LINE_DEPTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [7:0]                      i_char_in,
    input  logic                            i_cfg_valid,
    input  logic [slefp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [slefp_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  slefp_pkg::t_cmd                 i_cmd,
    output slefp_pkg::t_stat                o_stat,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic [1:0]                      o_item_kind,
    output logic [7:0]                      o_byte_value,
    output logic                            o_accepted,
    output logic                            o_frame_done,
    output logic signed [15:0]              o_speed_a,
    output logic signed [15:0]              o_speed_b,
    output logic signed [15:0]              o_speed_c,
    output logic signed [15:0]              o_speed_d,
    output logic                            o_line_done,
    output logic [slefp_pkg::CNT_W-1:0]     o_line_length,
    output logic                            o_last_item
);

    import slefp_pkg::*;

    localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic             r_binary_mode;
    logic             r_echo_en;
    logic             r_accept_en;
    logic [CNT_W-1:0] r_line_limit;

    logic [7:0]       r_char;
    logic [POS_W-1:0] r_frame_pos;
    logic [POS_W-1:0] n_frame_pos;
    logic [15:0]      r_frame_words [4];
    logic [15:0]      n_frame_words [4];
    logic             frame_hit;
    logic [1:0]       w_idx;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] n_idx;
    logic [CNT_W-1:0] w_limit;
    logic [7:0]       rd_data;

    logic             r_acc;
    logic             r_fdone;
    logic             r_ldone;
    logic [CNT_W-1:0] r_len;

    logic              r_out_valid;
    t_item_kind        r_out_kind;
    logic [7:0]        r_out_byte;
    logic              r_out_acc;
    logic              r_out_fdone;
    logic [15:0]       r_out_speed [4];
    logic              r_out_ldone;
    logic [CNT_W-1:0]  r_out_len;
    logic              r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_binary_mode <= 1'b0;
            r_echo_en     <= 1'b0;
            r_accept_en   <= 1'b1;
            r_line_limit  <= CNT_W'(32);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_BINARY_MODE:   r_binary_mode <= i_cfg_data[0];
                CFG_ECHO_ENABLE:   r_echo_en     <= i_cfg_data[0];
                CFG_ACCEPT_ENABLE: r_accept_en   <= i_cfg_data[0];
                CFG_LINE_LIMIT:    r_line_limit  <= i_cfg_data;
                default:           r_line_limit  <= r_line_limit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_char) begin
            r_char <= i_char_in;
        end
    end

    always_comb begin
        n_frame_pos   = r_frame_pos;
        n_frame_words = r_frame_words;
        frame_hit     = 1'b0;
        w_idx         = 2'((r_frame_pos - FRAME_FIRST) >> 1);
        if (i_cmd.frame_step) begin
            priority if (r_frame_pos == FRAME_IDLE && r_char == CH_START) begin
                n_frame_pos = FRAME_FIRST;
            end else if (r_frame_pos >= FRAME_FIRST && r_frame_pos <= FRAME_LAST) begin
                if (r_frame_pos[0]) begin
                    n_frame_words[w_idx] = {8'h00, r_char};
                end else begin
                    n_frame_words[w_idx] = r_frame_words[w_idx] + {r_char, 8'h00};
                end
                n_frame_pos = r_frame_pos + POS_W'(1);
            end else if (r_frame_pos == FRAME_END && r_char == CH_CR) begin
                frame_hit   = 1'b1;
                n_frame_pos = FRAME_IDLE;
            end else begin
                n_frame_pos = FRAME_IDLE;
            end
        end
    end

    always_comb begin
        n_fill = r_fill;
        priority if (i_cmd.line_end) begin
            n_fill = '0;
        end else if (i_cmd.store_char) begin
            n_fill = r_fill + CNT_W'(1);
        end else if (i_cmd.fill_dec) begin
            n_fill = r_fill - CNT_W'(1);
        end
        n_idx = r_idx;
        priority if (i_cmd.line_end) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_pos   <= FRAME_IDLE;
            r_frame_words <= '{default: '0};
            r_fill        <= '0;
            r_idx         <= '0;
        end else begin
            r_frame_pos   <= n_frame_pos;
            r_frame_words <= n_frame_words;
            r_fill        <= n_fill;
            r_idx         <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.status_load) begin
            r_acc   <= i_cmd.status_acc;
            r_fdone <= i_cmd.frame_step & frame_hit;
            r_ldone <= i_cmd.line_end;
            r_len   <= i_cmd.line_end ? r_fill : '0;
        end
    end

    // The read address is n_idx, the next value of r_idx, so that the data for r_idx is ready.
    slefp_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.store_char),
        .i_wr_addr (r_fill[ADDR_W-1:0]),
        .i_wr_data (r_char),
        .i_rd_addr (n_idx[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign w_limit = (r_line_limit > CNT_W'(LINE_DEPTH)) ? CNT_W'(LINE_DEPTH) : r_line_limit;

    always_comb begin
        o_stat.binary_mode = r_binary_mode;
        o_stat.echo_en     = r_echo_en;
        o_stat.accept_en   = r_accept_en;
        o_stat.is_eol      = (r_char == CH_CR) || (r_char == CH_LF);
        o_stat.is_bs       = (r_char == CH_BS);
        o_stat.fill_zero   = (r_fill == '0);
        o_stat.full        = (r_fill >= w_limit);
        o_stat.dump_last   = ((r_idx + CNT_W'(1)) == r_len);
        o_stat.out_free    = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind  <= KIND_ECHO;
            r_out_byte  <= 8'h00;
            r_out_acc   <= 1'b0;
            r_out_fdone <= 1'b0;
            r_out_speed <= '{default: '0};
            r_out_ldone <= 1'b0;
            r_out_len   <= '0;
            r_out_last  <= 1'b0;
            unique case (i_cmd.out_sel)
                SEL_CHAR: r_out_byte <= r_char;
                SEL_BS:   r_out_byte <= CH_BS;
                SEL_SP:   r_out_byte <= CH_SP;
                SEL_LINE: begin
                    r_out_kind <= KIND_LINE;
                    r_out_byte <= rd_data;
                end
                SEL_STATUS: begin
                    r_out_kind  <= KIND_STATUS;
                    r_out_acc   <= r_acc;
                    r_out_fdone <= r_fdone;
                    if (r_fdone) begin
                        r_out_speed <= r_frame_words;
                    end
                    r_out_ldone <= r_ldone;
                    r_out_len   <= r_len;
                    r_out_last  <= 1'b1;
                end
                default: r_out_kind <= KIND_ECHO;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_item_kind   = r_out_kind;
    assign o_byte_value  = r_out_byte;
    assign o_accepted    = r_out_acc;
    assign o_frame_done  = r_out_fdone;
    assign o_speed_a     = r_out_speed[0];
    assign o_speed_b     = r_out_speed[1];
    assign o_speed_c     = r_out_speed[2];
    assign o_speed_d     = r_out_speed[3];
    assign o_line_done   = r_out_ldone;
    assign o_line_length = r_out_len;
    assign o_last_item   = r_out_last;

endmodule

### hw/rtl/serial_line_editor_frame_parser_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                       Payload
// input     in         i_in_valid / o_in_stall         i_char_in
// result    out        o_out_valid / i_out_stall       o_item_kind .. o_last_item
// config    in         i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// One byte request is taken at a time; each byte passes through the execute state, then
// any echo bytes, then the status result; an end of line first dumps the stored line.
// The dump reads one stored entry per cycle through the registered read unless stalled.
// Reset is synchronous and active low and clears the configuration, the frame parser
// and the fill count. A stalled result holds the sequencer in place; the next byte
// request is taken once the status result has entered the output register.

module serial_line_editor_frame_parser_top #(
    parameter int LINE_DEPTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_char_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_item_kind,
    output logic [7:0]                      o_byte_value,
    output logic                            o_accepted,
    output logic                            o_frame_done,
    output logic signed [15:0]              o_speed_a,
    output logic signed [15:0]              o_speed_b,
    output logic signed [15:0]              o_speed_c,
    output logic signed [15:0]              o_speed_d,
    output logic                            o_line_done,
    output logic [slefp_pkg::CNT_W-1:0]     o_line_length,
    output logic                            o_last_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [slefp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [slefp_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    import slefp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    slefp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    slefp_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_char_in     (i_char_in),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_item_kind   (o_item_kind),
        .o_byte_value  (o_byte_value),
        .o_accepted    (o_accepted),
        .o_frame_done  (o_frame_done),
        .o_speed_a     (o_speed_a),
        .o_speed_b     (o_speed_b),
        .o_speed_c     (o_speed_c),
        .o_speed_d     (o_speed_d),
        .o_line_done   (o_line_done),
        .o_line_length (o_line_length),
        .o_last_item   (o_last_item)
    );

endmodule

### tb/tb_serial_line_editor_frame_parser_top.sv
`timescale 1ns / 1ps

module tb_serial_line_editor_frame_parser_top;
    import slefp_pkg::*;

    localparam int LINE_DEPTH  = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        t_item_kind         kind;
        logic [7:0]         val;
        logic               acc;
        logic               fdone;
        logic signed [15:0] sa;
        logic signed [15:0] sb;
        logic signed [15:0] sc;
        logic signed [15:0] sd;
        logic               ldone;
        logic [CNT_W-1:0]   len;
        logic               last;
    } out_item_t;

    typedef enum logic {
        ROW_BYTE,
        ROW_CFG
    } row_kind_e;

    typedef struct {
        row_kind_e  kind;
        t_cfg_index idx;
        logic [7:0] data;
        bit         typed;
        out_item_t  want;
    } stim_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [7:0]           i_char_in;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [1:0]           o_item_kind;
    logic [7:0]           o_byte_value;
    logic                 o_accepted;
    logic                 o_frame_done;
    logic signed [15:0]   o_speed_a;
    logic signed [15:0]   o_speed_b;
    logic signed [15:0]   o_speed_c;
    logic signed [15:0]   o_speed_d;
    logic                 o_line_done;
    logic [CNT_W-1:0]     o_line_length;
    logic                 o_last_item;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    serial_line_editor_frame_parser_top #(
        .LINE_DEPTH(LINE_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_char_in    (i_char_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_item_kind  (o_item_kind),
        .o_byte_value (o_byte_value),
        .o_accepted   (o_accepted),
        .o_frame_done (o_frame_done),
        .o_speed_a    (o_speed_a),
        .o_speed_b    (o_speed_b),
        .o_speed_c    (o_speed_c),
        .o_speed_d    (o_speed_d),
        .o_line_done  (o_line_done),
        .o_line_length(o_line_length),
        .o_last_item  (o_last_item),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    logic             m_binary;
    logic             m_echo;
    logic             m_accept;
    logic [5:0]       m_limit;
    logic [POS_W-1:0] m_pos;
    logic [15:0]      m_words [4];
    logic [7:0]       m_store [LINE_DEPTH];
    logic [CNT_W-1:0] m_fill;

    out_item_t owed_items[$];
    stim_row_t stim_rows[$];
    int        fails;
    int        cycle_count;
    int        phase_bytes;
    bit        tx_quiet;
    bit        rx_quiet;
    bit        hold_req;
    bit        hold_taken;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report(input string msg);
        if (fails < 100) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
        fails++;
    endtask

    task automatic compare_field(input string name, input longint got, input longint want);
        if (got != want) begin
            report($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    function automatic void owe_byte(input t_item_kind kind, input logic [7:0] v);
        out_item_t it;
        it = '0;
        it.kind = kind;
        it.val = v;
        owed_items.push_back(it);
    endfunction

    function automatic void owe_status(input logic acc, input logic fdone, input logic ldone,
                                       input logic [CNT_W-1:0] len);
        out_item_t it;
        it = '0;
        it.kind = KIND_STATUS;
        it.acc = acc;
        it.fdone = fdone;
        if (fdone) begin
            it.sa = m_words[0];
            it.sb = m_words[1];
            it.sc = m_words[2];
            it.sd = m_words[3];
        end
        it.ldone = ldone;
        it.len = len;
        it.last = 1'b1;
        owed_items.push_back(it);
    endfunction

    function automatic void parse_byte(input logic [7:0] c);
        logic [POS_W-1:0] p;
        logic             fdone;
        int               wi;
        int               lim;
        if (m_binary) begin
            p = m_pos;
            fdone = 1'b0;
            if (p == FRAME_IDLE && c == CH_START) begin
                m_pos = FRAME_FIRST;
            end else if (p >= FRAME_FIRST && p <= FRAME_LAST) begin
                wi = (int'(p) - 1) >> 1;
                if (p[0]) begin
                    m_words[wi] = {8'h00, c};
                end else begin
                    m_words[wi] = m_words[wi] + {c, 8'h00};
                end
                m_pos = p + 1'b1;
            end else if (p == FRAME_END && c == CH_CR) begin
                fdone = 1'b1;
                m_pos = FRAME_IDLE;
            end else begin
                m_pos = FRAME_IDLE;
            end
            owe_status(1'b1, fdone, 1'b0, '0);
        end else if (c == CH_CR || c == CH_LF) begin
            for (int i = 0; i < m_fill; i++) begin
                owe_byte(KIND_LINE, m_store[i]);
            end
            owe_status(1'b1, 1'b0, 1'b1, m_fill);
            m_fill = '0;
        end else if (c == CH_BS) begin
            if (!m_accept) begin
                owe_status(1'b0, 1'b0, 1'b0, '0);
            end else begin
                if (m_fill > 0) begin
                    m_fill = m_fill - 1'b1;
                    if (m_echo) begin
                        owe_byte(KIND_ECHO, CH_BS);
                        owe_byte(KIND_ECHO, CH_SP);
                        owe_byte(KIND_ECHO, CH_BS);
                    end
                end
                owe_status(1'b1, 1'b0, 1'b0, '0);
            end
        end else begin
            lim = (m_limit > LINE_DEPTH) ? LINE_DEPTH : int'(m_limit);
            if (m_fill >= lim || !m_accept) begin
                owe_status(1'b0, 1'b0, 1'b0, '0);
            end else begin
                if (m_echo) begin
                    owe_byte(KIND_ECHO, c);
                end
                m_store[m_fill] = c;
                m_fill = m_fill + 1'b1;
                owe_status(1'b1, 1'b0, 1'b0, '0);
            end
        end
    endfunction

    // Called and returning at a rising edge, the request still offered after acceptance.
    task automatic send_byte(input logic [7:0] c);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_in <= c;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        parse_byte(c);
        phase_bytes++;
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DAT_W-1:0] v);
        i_in_valid <= 1'b0;
        while (owed_items.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_BINARY_MODE:   m_binary = v[0];
            CFG_ECHO_ENABLE:   m_echo = v[0];
            CFG_ACCEPT_ENABLE: m_accept = v[0];
            CFG_LINE_LIMIT:    m_limit = v;
            default: ;
        endcase
    endtask

    function automatic void cfg_row(input t_cfg_index idx, input logic [7:0] v);
        stim_row_t r;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = v;
        r.typed = 1'b0;
        r.want = '0;
        stim_rows.push_back(r);
    endfunction

    function automatic void byte_row(input logic [7:0] c, input bit typed = 0, input bit acc = 0,
                                     input bit fdone = 0, input bit ldone = 0, input int len = 0,
                                     input int sa = 0, input int sb = 0, input int sc = 0,
                                     input int sd = 0);
        stim_row_t r;
        r.kind = ROW_BYTE;
        r.idx = CFG_BINARY_MODE;
        r.data = c;
        r.typed = typed;
        r.want = '0;
        r.want.kind = KIND_STATUS;
        r.want.acc = acc;
        r.want.fdone = fdone;
        r.want.sa = sa[15:0];
        r.want.sb = sb[15:0];
        r.want.sc = sc[15:0];
        r.want.sd = sd[15:0];
        r.want.ldone = ldone;
        r.want.len = len[CNT_W-1:0];
        r.want.last = 1'b1;
        stim_rows.push_back(r);
    endfunction

    function automatic logic [7:0] text_byte(input int eol_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < eol_pct) begin
            return ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF;
        end
        if (r < eol_pct + 12) begin
            return CH_BS;
        end
        if (r < eol_pct + 27) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'($urandom_range(32, 126));
    endfunction

    // Mostly well-formed frames with random payloads; some have a bad start or end
    // byte, and some are cut short so the next start byte lands where a payload or end byte is due.
    task automatic send_frame();
        logic [7:0] f [10];
        int         flaw;
        int         n;
        f[0] = CH_START;
        for (int i = 1; i <= 8; i++) begin
            if ($urandom_range(0, 5) == 0) begin
                f[i] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            end else begin
                f[i] = 8'($urandom_range(0, 255));
            end
        end
        f[9] = CH_CR;
        n = 10;
        flaw = $urandom_range(0, 7);
        if (flaw == 0) begin
            f[0] = 8'($urandom_range(0, 255));
        end else if (flaw == 1) begin
            f[9] = ($urandom_range(0, 1) != 0) ? CH_START : 8'($urandom_range(0, 255));
        end else if (flaw == 2) begin
            n = $urandom_range(1, 9);
        end
        for (int i = 0; i < n; i++) begin
            send_byte(f[i]);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        out_item_t w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_items.size() == 0) begin
                report("result arrived with nothing expected");
            end else begin
                w = owed_items.pop_front();
                compare_field("item_kind", o_item_kind, w.kind);
                compare_field("byte_value", o_byte_value, w.val);
                compare_field("accepted", o_accepted, w.acc);
                compare_field("frame_done", o_frame_done, w.fdone);
                compare_field("speed_a", o_speed_a, w.sa);
                compare_field("speed_b", o_speed_b, w.sb);
                compare_field("speed_c", o_speed_c, w.sc);
                compare_field("speed_d", o_speed_d, w.sd);
                compare_field("line_done", o_line_done, w.ldone);
                compare_field("line_length", o_line_length, w.len);
                compare_field("last_item", o_last_item, w.last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : result_stall
        int wait_n;
        i_out_stall = 1'b0;
        forever begin
            if (hold_req && !hold_taken) begin
                wait_n = HOLD_CYCLES;
                hold_taken = 1'b1;
            end else begin
                wait_n = rx_quiet ? 0 : $urandom_range(0, 19);
            end
            if (wait_n > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        logic             bin;
        logic             ech;
        logic             acc;
        logic [5:0]       lim;
        int               eol_pct;
        int               budget;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_char_in = 8'h00;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_BINARY_MODE;
        i_cfg_data = '0;
        fails = 0;
        cycle_count = 0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        hold_req = 1'b0;
        hold_taken = 1'b0;
        m_binary = 1'b0;
        m_echo = 1'b0;
        m_accept = 1'b1;
        m_limit = 6'd32;
        m_pos = FRAME_IDLE;
        m_fill = '0;
        for (int i = 0; i < 4; i++) m_words[i] = '0;
        for (int i = 0; i < LINE_DEPTH; i++) m_store[i] = '0;

        byte_row(8'h41, 1, 1);
        byte_row(CH_CR, 1, 1, 0, 1, 1);
        byte_row(CH_BS, 1, 1);
        byte_row(CH_LF, 1, 1, 0, 1, 0);
        cfg_row(CFG_ECHO_ENABLE, 8'd1);
        byte_row(8'h00);
        byte_row(8'hFF);
        byte_row(CH_BS);
        cfg_row(CFG_ACCEPT_ENABLE, 8'd0);
        byte_row(8'h78, 1, 0);
        byte_row(CH_BS, 1, 0);
        byte_row(CH_CR, 1, 1, 0, 1, 1);
        cfg_row(CFG_ACCEPT_ENABLE, 8'd1);
        cfg_row(CFG_LINE_LIMIT, 8'd0);
        byte_row(8'h79, 1, 0);
        cfg_row(CFG_LINE_LIMIT, 8'd1);
        byte_row(8'h61);
        byte_row(8'h62, 1, 0);
        byte_row(CH_LF, 1, 1, 0, 1, 1);
        cfg_row(CFG_BINARY_MODE, 8'd1);
        byte_row(CH_START);
        byte_row(8'h00);
        byte_row(8'h80);
        byte_row(8'hFF);
        byte_row(8'h7F);
        byte_row(8'hFF);
        byte_row(8'hFF);
        byte_row(8'h01);
        byte_row(8'h00);
        byte_row(CH_CR, 1, 1, 1, 0, 0, -32768, 32767, -1, 1);
        byte_row(8'h5A, 1, 1);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_CFG) begin
                write_reg(stim_rows[i].idx, stim_rows[i].data[CFG_DAT_W-1:0]);
            end else begin
                send_byte(stim_rows[i].data);
                if (stim_rows[i].typed) begin
                    owed_items[$] = stim_rows[i].want;
                end
            end
        end

        for (int p = 0; p < 10; p++) begin
            bin = (p == 2) || (p > 3 && $urandom_range(0, 2) == 0);
            ech = (p == 0 || p == 3) ? 1'b1 : 1'($urandom_range(0, 1));
            acc = (p < 4) || ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 4))
                0: lim = 6'd0;
                1: lim = 6'd1;
                2: lim = 6'd32;
                3: lim = 6'd63;
                default: lim = 6'($urandom_range(0, 63));
            endcase
            if (p == 0) lim = 6'd63;
            if (p == 1) lim = 6'd3;
            eol_pct = (p == 0 || $urandom_range(0, 3) == 0) ? 2 : 10;
            budget = (p == 0) ? 60 : 20;
            write_reg(CFG_BINARY_MODE, CFG_DAT_W'(bin));
            write_reg(CFG_ECHO_ENABLE, CFG_DAT_W'(ech));
            write_reg(CFG_ACCEPT_ENABLE, CFG_DAT_W'(acc));
            write_reg(CFG_LINE_LIMIT, lim);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if (p == 3) begin
                hold_req = 1'b1;
            end
            phase_bytes = 0;
            while (phase_bytes < budget) begin
                if (m_binary) begin
                    send_frame();
                end else begin
                    send_byte(text_byte(eol_pct));
                end
            end
        end

        i_in_valid <= 1'b0;
        while (owed_items.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
